// File: hdl/secret_value_redaction_filter_core_defines.svh
// Assertion macros for the redaction filter.
// Each macro takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef SECRET_VALUE_REDACTION_FILTER_CORE_DEFINES_SVH
`define SECRET_VALUE_REDACTION_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SVRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SVRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SVRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SVRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/svrf_pkg.sv
`default_nettype none

package svrf_pkg;

    localparam int HIST_DEPTH = 13;
    localparam int TAG_COUNT  = 5;
    localparam int TAG_MAX    = 14;
    localparam int TAG_BITS   = TAG_MAX * 8;
    localparam int FILL_LEN   = 10;
    localparam int FILL_IDX_W = $clog2(FILL_LEN);

    // Markers, right-aligned: byte 0 is the last character of the marker.
    localparam logic [TAG_BITS-1:0] TAG_STR [TAG_COUNT] = '{
        TAG_BITS'("password="),
        TAG_BITS'("api_key="),
        TAG_BITS'("token="),
        TAG_BITS'({"access_", "token="}),
        TAG_BITS'("Authorization:")
    };
    localparam int TAG_LEN [TAG_COUNT] = '{9, 8, 6, 13, 14};

    // Replacement text, first character at index 0.
    localparam logic [7:0] FILL_TEXT [FILL_LEN] = '{
        "<", "r", "e", "d", "a", "c", "t", "e", "d", ">"
    };

    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;

    // Decision for one accepted byte, handed from matcher to emitter.
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       carries;
        logic       eot;
        logic       burst;
        logic       fin;
    } match_result_t;

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_AMP) || (c == CH_SP) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

// File: hdl/svrf_in_if.sv
`default_nettype none

interface svrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/svrf_out_if.sv
`default_nettype none

interface svrf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       carries_byte;
    logic       end_of_text;

    modport source (output valid, output out_byte, output carries_byte,
                    output end_of_text, input ready);
    modport sink (input valid, input out_byte, input carries_byte,
                  input end_of_text, output ready);
endinterface

`default_nettype wire

// File: hdl/svrf_matcher.sv
`default_nettype none

module svrf_matcher (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              text_byte,
    input  logic                    final_byte,
    output svrf_pkg::match_result_t result
);
    import svrf_pkg::*;

    logic [7:0]           hist_reg  [HIST_DEPTH];
    logic [7:0]           hist_next [HIST_DEPTH];
    logic                 drop_reg;
    logic                 drop_next;
    logic [7:0]           window [TAG_MAX];
    logic [TAG_COUNT-1:0] tag_hit;
    logic                 hit;

    // Window of newest bytes: index 0 is the incoming byte
    always_comb
    begin
        window[0] = text_byte;
        for (int i = 1; i < TAG_MAX; i++)
        begin
            window[i] = hist_reg[HIST_DEPTH - i];
        end
    end

    // Parallel compare against every marker
    always_comb
    begin
        for (int t = 0; t < TAG_COUNT; t++)
        begin
            tag_hit[t] = 1'b1;
            for (int i = 0; i < TAG_MAX; i++)
            begin
                if (i < TAG_LEN[t] && window[i] != TAG_STR[t][8*i +: 8])
                begin
                    tag_hit[t] = 1'b0;
                end
            end
        end
    end

    assign hit = |tag_hit;

    // Decision and next state for the byte on the input
    always_comb
    begin
        result         = '0;
        result.fin     = final_byte;
        result.data    = text_byte;
        result.carries = 1'b1;
        hist_next      = hist_reg;
        drop_next      = drop_reg;

        if (drop_reg)
        begin
            if (is_delim(text_byte))
            begin
                result.emit = 1'b1;
                result.eot  = final_byte;
                drop_next   = 1'b0;
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    hist_next[i] = '0;
                end
            end
            else if (final_byte)
            begin
                // end-only result
                result.emit    = 1'b1;
                result.data    = '0;
                result.carries = 1'b0;
                result.eot     = 1'b1;
            end
        end
        else if (hit)
        begin
            result.emit  = 1'b1;
            result.burst = 1'b1;
            drop_next    = 1'b1;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_next[i] = '0;
            end
        end
        else
        begin
            result.emit = 1'b1;
            result.eot  = final_byte;
            for (int i = 0; i < HIST_DEPTH - 1; i++)
            begin
                hist_next[i] = hist_reg[i + 1];
            end
            hist_next[HIST_DEPTH - 1] = text_byte;
        end

        // end of text starts a fresh one
        if (final_byte)
        begin
            drop_next = 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_next[i] = '0;
            end
        end
    end

    // History and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            drop_reg <= drop_next;
            hist_reg <= hist_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/svrf_emitter.sv
`default_nettype none

module svrf_emitter (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  svrf_pkg::match_result_t result,
    output logic                    in_ready,
    output logic                    busy,
    svrf_out_if.source              text_out
);
    import svrf_pkg::*;

    localparam logic [FILL_IDX_W-1:0] FILL_LAST = FILL_IDX_W'(FILL_LEN - 1);

    logic                  valid_reg,   valid_next;
    logic [7:0]            byte_reg,    byte_next;
    logic                  carries_reg, carries_next;
    logic                  eot_reg,     eot_next;
    logic                  busy_reg,    busy_next;
    logic [FILL_IDX_W-1:0] idx_reg,     idx_next;
    logic                  fin_reg,     fin_next;
    logic                  load;

    // Result register may take a new value when empty or being drained
    assign load     = !valid_reg || text_out.ready;
    assign in_ready = !busy_reg && load;
    assign busy     = busy_reg;

    always_comb
    begin
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        carries_next = carries_reg;
        eot_next     = eot_reg;
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        fin_next     = fin_reg;

        if (load)
        begin
            if (busy_reg)
            begin
                // replacement burst
                valid_next   = 1'b1;
                byte_next    = FILL_TEXT[idx_reg];
                carries_next = 1'b1;
                eot_next     = fin_reg && (idx_reg == FILL_LAST);
                if (idx_reg == FILL_LAST)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            else if (accept && result.emit)
            begin
                valid_next   = 1'b1;
                byte_next    = result.data;
                carries_next = result.carries;
                eot_next     = result.eot;
                busy_next    = result.burst;
                idx_next     = '0;
                fin_next     = result.fin;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        carries_reg <= carries_next;
        eot_reg     <= eot_next;
        fin_reg     <= fin_next;
    end

    assign text_out.valid        = valid_reg;
    assign text_out.out_byte     = byte_reg;
    assign text_out.carries_byte = carries_reg;
    assign text_out.end_of_text  = eot_reg;

endmodule

`default_nettype wire

// File: hdl/secret_value_redaction_filter_core.sv
// Each accepted byte's result is loaded into the output register as the byte is accepted.
// Throughput: one byte per cycle while the output is ready; a completed marker holds the input
// while the ten bytes of replacement text leave the output register.
// Reset: rst_n asynchronous, active low; clears match history, drop flag and output.
`default_nettype none

`include "secret_value_redaction_filter_core_defines.svh"

module secret_value_redaction_filter_core (
    input  logic       clk,
    input  logic       rst_n,
    svrf_in_if.sink    text_in,
    svrf_out_if.source text_out
);
    import svrf_pkg::*;

    match_result_t result;
    logic          accept;
    logic          in_ready;
    logic          busy;

    assign text_in.ready = in_ready;
    assign accept        = text_in.valid && in_ready;

    // Marker detection and drop tracking
    svrf_matcher u_matcher (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_byte  (text_in.text_byte),
        .final_byte (text_in.final_byte),
        .result     (result)
    );

    // Output register and replacement burst
    svrf_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .result   (result),
        .in_ready (in_ready),
        .busy     (busy),
        .text_out (text_out)
    );

    // Checks
    `SVRF_ASSERT_NOW(a_no_take_in_burst, clk, rst_n, busy, !text_in.ready, "input taken during burst")
    `SVRF_ASSERT_NOW(a_burst_has_output, clk, rst_n, busy, text_out.valid, "burst without output")
    `SVRF_ASSERT_NEXT(a_hit_starts_burst, clk, rst_n, accept && result.emit && result.burst, busy, "marker hit without burst")
    `SVRF_ASSERT_NOW(a_end_only_shape, clk, rst_n, text_out.valid && !text_out.carries_byte, text_out.end_of_text && text_out.out_byte == 8'h00, "bad end-only result")

endmodule

`default_nettype wire

// File: dv/tb_secret_value_redaction_filter_core.sv
`timescale 1ns / 100ps

// Expected output stream of the redaction filter, checked in transfer order.
typedef struct packed {
    logic [7:0] out_byte;
    logic       carries_byte;
    logic       end_of_text;
} redact_out_t;

class redaction_scoreboard;
    string       markers[5];
    string       fill_text;
    logic [7:0]  recent[13];
    bit          dropping;
    redact_out_t expected_q[$];
    int          errors;

    function new();
        markers   = '{"password=", "api_key=", "token=", {"access_", "token="},
                      "Authorization:"};
        fill_text = "<redacted>";
        errors    = 0;
        restart_text();
    endfunction

    function void clear_history();
        foreach (recent[i]) recent[i] = 8'h00;
    endfunction

    function void restart_text();
        clear_history();
        dropping = 1'b0;
    endfunction

    function bit is_separator(logic [7:0] c);
        return c == 8'h26 || c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
    endfunction

    // Marker t completes on c given the bytes passed so far.
    function bit marker_ends_here(int t, logic [7:0] c);
        int n;
        logic [7:0] m;
        n = markers[t].len();
        m = markers[t][n-1];
        if (m != c) return 1'b0;
        for (int k = 0; k < n - 1; k++) begin
            m = markers[t][n-2-k];
            if (recent[12-k] != m) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void push(logic [7:0] b, logic has, logic eot);
        redact_out_t r;
        r.out_byte     = b;
        r.carries_byte = has;
        r.end_of_text  = eot;
        expected_q = {expected_q, r};
    endfunction

    // Predict the results of one accepted byte; returns how many it causes.
    function int note_input(logic [7:0] c, logic fin);
        int  n_prior;
        bit  hit;
        logic [7:0] f;
        n_prior = expected_q.size();
        hit     = 1'b0;
        if (dropping) begin
            if (is_separator(c)) begin
                push(c, 1'b1, fin);
                restart_text();
            end else if (fin) begin
                push(8'h00, 1'b0, 1'b1);
            end
        end else begin
            for (int t = 0; t < 5; t++)
                if (marker_ends_here(t, c)) hit = 1'b1;
            if (hit) begin
                push(c, 1'b1, 1'b0);
                for (int k = 0; k < 10; k++) begin
                    f = fill_text[k];
                    push(f, 1'b1, (k == 9) ? fin : 1'b0);
                end
                clear_history();
                dropping = 1'b1;
            end else begin
                for (int i = 0; i < 12; i++) recent[i] = recent[i+1];
                recent[12] = c;
                push(c, 1'b1, fin);
            end
        end
        if (fin) restart_text();
        return expected_q.size() - n_prior;
    endfunction

    function void check_result(logic [7:0] b, logic has, logic eot);
        redact_out_t e;
        if (expected_q.size() == 0) begin
            $error("unexpected result: out_byte 0x%02h carries_byte %0b end_of_text %0b",
                   b, has, eot);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (b !== e.out_byte) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", e.out_byte, b);
            errors++;
        end
        if (has !== e.carries_byte) begin
            $error("carries_byte: expected %0b, actual %0b", e.carries_byte, has);
            errors++;
        end
        if (eot !== e.end_of_text) begin
            $error("end_of_text: expected %0b, actual %0b", e.end_of_text, eot);
            errors++;
        end
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction
endclass

module tb_secret_value_redaction_filter_core;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    svrf_in_if  text_in_bus ();
    svrf_out_if text_out_bus ();

    secret_value_redaction_filter_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in_bus.sink),
        .text_out (text_out_bus.source)
    );

    redaction_scoreboard sb;
    int         counted;
    bit         calm;
    logic [7:0] seg_q[$];

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One byte transfer on the input channel
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int g;
        g = idle_len();
        if (g > 0)
        begin
            text_in_bus.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        text_in_bus.valid      <= 1'b1;
        text_in_bus.text_byte  <= b;
        text_in_bus.final_byte <= fin;
        do @(posedge clk); while (!text_in_bus.ready);
        void'(sb.note_input(b, fin));
        counted++;
    endtask

    task automatic send_text(input string s, input bit fin_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_last && (i == s.len() - 1));
    endtask

    function automatic void add_byte(logic [7:0] c);
        seg_q = {seg_q, c};
    endfunction

    function automatic void add_string(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    // Any byte that does not end a dropped value
    function automatic logic [7:0] value_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (sb.is_separator(c));
        return c;
    endfunction

    function automatic logic [7:0] separator_char();
        case ($urandom_range(0, 4))
            0: return 8'h26;
            1: return 8'h20;
            2: return 8'h0A;
            3: return 8'h0D;
            default: return 8'h09;
        endcase
    endfunction

    // Build one random piece of text into seg_q; returns whether it ends the text
    function automatic bit build_segment();
        int    kind;
        int    pos;
        int    vlen;
        string m;
        bit    fin;
        seg_q.delete();
        fin  = ($urandom_range(0, 99) < 30);
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            // well-formed: filler, marker, value, separator or end of text
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
            add_string(sb.markers[$urandom_range(0, 4)]);
            vlen = $urandom_range(0, 8);
            for (int i = 0; i < vlen; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_string(sb.markers[$urandom_range(0, 4)]);
                else
                    add_byte(value_char());
            end
            if (!fin || $urandom_range(0, 1) == 1) add_byte(separator_char());
        end
        else if (kind < 85)
        begin
            // broken marker: cut short, one byte changed, or wrong case
            m   = sb.markers[$urandom_range(0, 4)];
            pos = $urandom_range(0, m.len() - 1);
            case ($urandom_range(0, 2))
                0: m = m.substr(0, m.len() - 2);
                1: m[pos] = value_char();
                default: m[0] = m[0] ^ 8'h20;
            endcase
            add_string(m);
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
        end
        return fin;
    endfunction

    // Result side: random back-pressure
    initial
    begin
        int g;
        text_out_bus.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            g = idle_len();
            if (g > 0)
            begin
                text_out_bus.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            text_out_bus.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(40, 100)) @(posedge clk);
            else
                repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && text_out_bus.valid && text_out_bus.ready)
            sb.check_result(text_out_bus.out_byte, text_out_bus.carries_byte,
                            text_out_bus.end_of_text);
    end

    // Run limit
    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus
    initial
    begin
        bit fin;
        bit paused;
        sb      = new();
        counted = 0;
        calm    = 1'b0;
        paused  = 1'b0;
        text_in_bus.valid      <= 1'b0;
        text_in_bus.text_byte  <= 8'h00;
        text_in_bus.final_byte <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: byte extremes, zero byte, match on the last byte,
        // dropped last byte, separator ending the text
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("token=", 1'b1);
        send_text("token=v", 1'b1);
        send_text("token=v\t", 1'b1);

        // Random texts
        while (counted < 385)
        begin
            calm = ($urandom_range(0, 3) == 0);
            fin  = build_segment();
            for (int i = 0; i < seg_q.size(); i++)
                send_byte(seg_q[i], fin && (i == seg_q.size() - 1));
            // hold off once until every result has drained
            if (!paused && counted >= 200)
            begin
                paused = 1'b1;
                text_in_bus.valid <= 1'b0;
                do @(posedge clk); while (sb.outstanding() != 0);
            end
        end
        text_in_bus.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
